// ----- sv/touch_slot_allocator_with_expiry_top_assert.svh -----
// Assertion macros for the touch slot allocator.
// Included by the top level; uses its i_clk and i_rst_n ports.
`ifndef TOUCH_SLOT_ALLOCATOR_WITH_EXPIRY_TOP_ASSERT_SVH
`define TOUCH_SLOT_ALLOCATOR_WITH_EXPIRY_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TSA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tsa_pkg.sv -----
// Shared types and constants for the touch slot allocator.
// Used by the controller, the datapath and the top level.
package tsa_pkg;

    localparam int NumSlots = 10;
    localparam int SlotW    = 4;
    localparam int CntW     = (NumSlots > 1) ? $clog2(NumSlots) : 1;

    localparam int InDataW  = 104;
    localparam int OutDataW = 24;

    localparam logic [2:0] REQ_ACQUIRE = 3'd0;
    localparam logic [2:0] REQ_RELEASE = 3'd1;
    localparam logic [2:0] REQ_REFRESH = 3'd2;
    localparam logic [2:0] REQ_EXPIRE  = 3'd3;
    localparam logic [2:0] REQ_QUERY   = 3'd4;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NOFREE = 2'd1;
    localparam logic [1:0] STAT_NOTREG = 2'd2;

    localparam logic [4:0] EV_ABS        = 5'd3;
    localparam logic [5:0] CODE_MT_SLOT  = 6'd47;
    localparam logic [5:0] CODE_TRACK_ID = 6'd57;
    localparam logic [4:0] VALUE_UP      = 5'h1f;

    localparam logic [31:0] ExpirationReset = 32'd1000000;

    typedef struct packed {
        logic [1:0]       status;
        logic [SlotW-1:0] slot;
        logic             id_found;
        logic             slot_used;
        logic             ev_valid;
        logic [4:0]       ev_type;
        logic [5:0]       ev_code;
        logic [4:0]       ev_value;
        logic             last;
    } t_result;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_step;
        logic emit_none;
        logic emit_slot;
        logic emit_track;
    } t_cmd;

    typedef struct packed {
        logic is_expire;
        logic scan_done;
        logic mask_any;
        logic mask_one;
        logic out_free;
    } t_status;

endpackage

// ----- sv/touch_slot_allocator_with_expiry_top.sv -----
// Touch slot allocator with expiry: maps touch identifiers to slots with deadlines.
// Input requests on s_axis, results on m_axis, one expiration register on the cfg channel.
// Depends on tsa_pkg, tsa_ctrl, tsa_dp and the assertion macro header.
//
// Requests enter on s_axis; tuser carries the request type. Each request gives one or
// more results on m_axis, the final one with tlast high. Acquire, release, refresh,
// query and unknown types are accepted in the idle state, then take a lookup step
// in which the identifier is compared against all slots at once and the result
// goes to the output register once it is free. An expire request instead scans every
// slot's deadline (one 64-bit compare a cycle) and gives a slot event and a track
// event per expired slot, or a single result when nothing expired. One request
// is handled at a time; s_axis_tready is high only while the sequencer is idle,
// and it is high even while a finished result still waits in the output register.
// A stalled receiver holds the output register and the sequencer waits on it.
// Reset clears all slots and the output valid flag and sets the expiration to 1000000.
// The cfg channel is always ready and should be written only while idle.
`include "touch_slot_allocator_with_expiry_top_assert.svh"
module touch_slot_allocator_with_expiry_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // identifier [31:0], slot_index [35:32], now_time [99:36], zero fill [103:100].
    input  logic [tsa_pkg::InDataW-1:0]   s_axis_tdata,
    // req_type [2:0].
    input  logic [2:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status [1:0], slot [5:2], id_found [6], slot_used [7], ev_type [12:8],
    // ev_code [18:13], ev_value [23:19].
    output logic [tsa_pkg::OutDataW-1:0]  m_axis_tdata,
    // ev_valid [0].
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);
    import tsa_pkg::*;

    t_cmd    cmd;
    t_status st;
    t_result res;

    tsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    tsa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_req_type   (s_axis_tuser),
        .i_identifier (s_axis_tdata[31:0]),
        .i_slot_index (s_axis_tdata[35:32]),
        .i_now_time   (s_axis_tdata[99:36]),
        .i_cmd        (cmd),
        .o_st         (st),
        .o_out        (res),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {res.ev_value, res.ev_code, res.ev_type, res.slot_used,
                           res.id_found, res.slot, res.status};
    assign m_axis_tuser = res.ev_valid;
    assign m_axis_tlast = res.last;

    `TSA_ASSERT_NXT(a_one_request, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")
    `TSA_ASSERT_IMP(a_no_overwrite, cmd.exec || cmd.emit_none || cmd.emit_slot || cmd.emit_track, st.out_free, "pending result overwritten")
    `TSA_ASSERT_IMP(a_slot_range, m_axis_tvalid, m_axis_tdata[5:2] < SlotW'(NumSlots), "result slot out of range")

endmodule

// ----- sv/tsa_ctrl.sv -----
// Request sequencer for the touch slot allocator.
// Depends on tsa_pkg for the command and status structs.
module tsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tsa_pkg::t_status i_st,
    output tsa_pkg::t_cmd    o_cmd
);
    import tsa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_TRACK = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_st.is_expire) begin
                    n_state = S_SCAN;
                end else if (i_st.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_st.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    if (i_st.mask_any) begin
                        o_cmd.emit_slot = 1'b1;
                        n_state         = S_TRACK;
                    end else begin
                        o_cmd.emit_none = 1'b1;
                        n_state         = S_IDLE;
                    end
                end
            end
            S_TRACK: begin
                if (i_st.out_free) begin
                    o_cmd.emit_track = 1'b1;
                    n_state          = i_st.mask_one ? S_IDLE : S_EMIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/tsa_dp.sv -----
// Slot table, lookup logic, expiry scan and output register of the allocator.
// Depends on tsa_pkg; driven by commands from tsa_ctrl.
module tsa_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [31:0]      i_cfg_data,
    input  logic [2:0]       i_req_type,
    input  logic [31:0]      i_identifier,
    input  logic [tsa_pkg::SlotW-1:0] i_slot_index,
    input  logic [63:0]      i_now_time,
    input  tsa_pkg::t_cmd    i_cmd,
    output tsa_pkg::t_status o_st,
    output tsa_pkg::t_result o_out,
    output logic             o_out_valid,
    input  logic             i_out_ready
);
    import tsa_pkg::*;

    logic [31:0]         r_expiration;
    logic [2:0]          r_req;
    logic [31:0]         r_id;
    logic [SlotW-1:0]    r_qslot;
    logic [63:0]         r_now;
    logic [NumSlots-1:0] r_valid;
    logic [31:0]         r_owner    [NumSlots];
    logic [63:0]         r_deadline [NumSlots];
    logic [NumSlots-1:0] r_mask;
    logic [CntW-1:0]     r_cnt;
    t_result             r_out;
    logic                r_out_valid;

    logic [NumSlots-1:0] hit;
    logic                hit_any;
    logic [CntW-1:0]     hit_idx;
    logic                free_any;
    logic [CntW-1:0]     free_idx;
    logic [CntW-1:0]     ev_idx;
    logic                q_used;
    logic [64:0]         dl_sum;
    logic [63:0]         dl_new;
    logic                out_free;
    t_result             exec_res;
    t_result             ev_res;
    logic [NumSlots-1:0] ev_bit;

    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        ev_idx   = '0;
        q_used   = 1'b0;
        for (int i = NumSlots - 1; i >= 0; i--) begin
            hit[i] = r_valid[i] && (r_owner[i] == r_id);
            if (hit[i]) begin
                hit_any = 1'b1;
                hit_idx = CntW'(i);
            end
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = CntW'(i);
            end
            if (r_mask[i]) begin
                ev_idx = CntW'(i);
            end
            if (r_qslot == SlotW'(i)) begin
                q_used = r_valid[i];
            end
        end
    end

    assign ev_bit = NumSlots'(1) << ev_idx;
    assign dl_sum = {1'b0, r_now} + {33'd0, r_expiration};
    assign dl_new = dl_sum[64] ? '1 : dl_sum[63:0];

    always_comb begin
        exec_res      = '0;
        exec_res.last = 1'b1;
        case (r_req)
            REQ_ACQUIRE: begin
                if (hit_any) begin
                    exec_res.slot     = SlotW'(hit_idx);
                    exec_res.id_found = 1'b1;
                end else if (free_any) begin
                    exec_res.slot     = SlotW'(free_idx);
                    exec_res.id_found = 1'b1;
                end else begin
                    exec_res.status = STAT_NOFREE;
                end
            end
            REQ_RELEASE: begin
                if (hit_any) begin
                    exec_res.slot = SlotW'(hit_idx);
                end
            end
            REQ_REFRESH, REQ_QUERY: begin
                if (hit_any) begin
                    exec_res.slot     = SlotW'(hit_idx);
                    exec_res.id_found = 1'b1;
                end else begin
                    exec_res.status = STAT_NOTREG;
                end
                exec_res.slot_used = (r_req == REQ_QUERY) && q_used;
            end
            default: begin
                exec_res.last = 1'b1;
            end
        endcase
    end

    always_comb begin
        ev_res          = '0;
        ev_res.slot     = SlotW'(ev_idx);
        ev_res.ev_valid = 1'b1;
        ev_res.ev_type  = EV_ABS;
        if (i_cmd.emit_track) begin
            ev_res.ev_code  = CODE_TRACK_ID;
            ev_res.ev_value = VALUE_UP;
            ev_res.last     = ((r_mask & ~ev_bit) == '0);
        end else begin
            ev_res.ev_code  = CODE_MT_SLOT;
            ev_res.ev_value = 5'(ev_idx);
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiration <= ExpirationReset;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_expiration <= i_cfg_data;
            end
            if (i_cmd.exec || i_cmd.emit_none || i_cmd.emit_slot || i_cmd.emit_track) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.exec) begin
                if (r_req == REQ_ACQUIRE && !hit_any && free_any) begin
                    r_valid[free_idx] <= 1'b1;
                end
                if (r_req == REQ_RELEASE && hit_any) begin
                    r_valid[hit_idx] <= 1'b0;
                end
            end
            if (i_cmd.emit_track) begin
                r_valid[ev_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req_type;
            r_id    <= i_identifier;
            r_qslot <= i_slot_index;
            r_now   <= i_now_time;
            r_cnt   <= '0;
        end
        if (i_cmd.exec || i_cmd.emit_none) begin
            r_out <= exec_res;
        end
        if (i_cmd.emit_slot || i_cmd.emit_track) begin
            r_out <= ev_res;
        end
        if (i_cmd.exec) begin
            if (r_req == REQ_ACQUIRE || r_req == REQ_REFRESH) begin
                if (hit_any) begin
                    r_deadline[hit_idx] <= dl_new;
                end else if (r_req == REQ_ACQUIRE && free_any) begin
                    r_deadline[free_idx] <= dl_new;
                    r_owner[free_idx]    <= r_id;
                end
            end
        end
        if (i_cmd.scan_step) begin
            r_mask[r_cnt] <= r_valid[r_cnt] && (r_deadline[r_cnt] < r_now);
            r_cnt         <= r_cnt + 1'b1;
        end
        if (i_cmd.emit_track) begin
            r_mask <= r_mask & ~ev_bit;
        end
    end

    assign o_st.is_expire = (r_req == REQ_EXPIRE);
    assign o_st.scan_done = (r_cnt == CntW'(NumSlots - 1));
    assign o_st.mask_any  = |r_mask;
    assign o_st.mask_one  = $onehot(r_mask);
    assign o_st.out_free  = out_free;
    assign o_out          = r_out;
    assign o_out_valid    = r_out_valid;

endmodule
